// ===== rtl/anisotropic_stencil_assembler_core_defines.svh =====
// Assertion macros shared by the stencil assembler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ANISOTROPIC_STENCIL_ASSEMBLER_CORE_DEFINES_SVH
`define ANISOTROPIC_STENCIL_ASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ASA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asa: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asa: next-cycle check failed");

`endif

// ===== rtl/asa_pkg.sv =====
// Shared widths, codes, types and arithmetic helpers of the stencil assembler.
// No dependencies; used by every module of the block.
package asa_pkg;

    localparam int DIM_W      = 11;
    localparam int RATIO_W    = 32;
    localparam int COEF_W     = 32;
    localparam int NUM_COEF   = 8;
    localparam int IN_TDATA_W = NUM_COEF * COEF_W;
    localparam int ROW_W      = 21;
    localparam int COL_W      = 20;
    localparam int VAL_W      = 40;
    localparam int OUT_BITS   = ROW_W + COL_W + VAL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_W      = RATIO_W + COEF_W + 1;
    localparam int FRAC_DROP  = 14;
    localparam int PROD_W     = MUL_W - FRAC_DROP;
    localparam int SUM_W      = COEF_W + 1;
    localparam int Q18_W      = 56;

    localparam int NUM_NB      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int STEP_W      = 4;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_YX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_XY    = 2'd3;

    localparam logic [2:0] NB_EAST  = 3'd0;
    localparam logic [2:0] NB_WEST  = 3'd1;
    localparam logic [2:0] NB_NORTH = 3'd2;
    localparam logic [2:0] NB_SOUTH = 3'd3;
    localparam logic [2:0] NB_NE    = 3'd4;
    localparam logic [2:0] NB_SW    = 3'd5;
    localparam logic [2:0] NB_NW    = 3'd6;
    localparam logic [2:0] NB_SE    = 3'd7;

    localparam logic [STEP_W-1:0] STEP_CENTRE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

    localparam logic signed [Q18_W-1:0] SAT_HI =
        {{(Q18_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [Q18_W-1:0] SAT_LO =
        {{(Q18_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic xlo;
        logic xhi;
        logic ylo;
        logic yhi;
    } border_t;

    typedef struct packed {
        logic xp;
        logic xm;
        logic yp;
        logic ym;
    } move_t;

    typedef struct packed {
        logic [ROW_W-1:0]              k;
        border_t                       border;
        logic [VAL_W-1:0]              centre;
        logic [NUM_NB-1:0][VAL_W-1:0]  nb_val;
    } cell_word_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [ROW_W-1:0] dummy;
    } cfg_view_t;

    function automatic move_t nb_move(input logic [2:0] idx, input border_t b);
        move_t want;
        move_t m;
        want = '0;
        unique case (idx)
            NB_EAST:  want.xp = 1'b1;
            NB_WEST:  want.xm = 1'b1;
            NB_NORTH: want.yp = 1'b1;
            NB_SOUTH: want.ym = 1'b1;
            NB_NE:    begin want.xp = 1'b1; want.yp = 1'b1; end
            NB_SW:    begin want.xm = 1'b1; want.ym = 1'b1; end
            NB_NW:    begin want.xm = 1'b1; want.yp = 1'b1; end
            NB_SE:    begin want.xp = 1'b1; want.ym = 1'b1; end
            default:  want = '0;
        endcase
        m.xp = want.xp & ~b.xhi;
        m.xm = want.xm & ~b.xlo;
        m.yp = want.yp & ~b.yhi;
        m.ym = want.ym & ~b.ylo;
        return m;
    endfunction

    function automatic logic is_folded(input move_t m);
        return ~(m.xp | m.xm | m.yp | m.ym);
    endfunction

    // round Q.18 to Q.16 (ties up), then saturate to the output width
    function automatic logic [VAL_W-1:0] finish(input logic signed [Q18_W-1:0] q);
        logic signed [Q18_W-1:0] r;
        r = (q + Q18_W'(2)) >>> 2;
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/anisotropic_stencil_assembler_core.sv =====
// A cell goes through the arithmetic pipe and the cell queue to the output register.
// Throughput: nine triples per cell, one per cycle unless m_axis_tready stalls the
// output register. Up to 4 cells are buffered ahead of it.
// Reset (rst_n low, asynchronous) restores default registers, returns the counters
// to cell (0,0) and empties the pipe and queue; no clearing pass follows.
module anisotropic_stencil_assembler_core #(
    parameter int MAX_WIDTH  = asa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = asa_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // east_xx, west_xx, north_yy, south_yy, north_xy, south_xy, east_yx, west_yx
    input  logic [asa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // row_index, col_index, coeff_value, zero pad
    output logic [asa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                cell_done;
    logic                push;
    asa_pkg::cell_word_t push_word;
    asa_pkg::cell_word_t head_word;
    logic                head_valid;
    asa_pkg::cfg_view_t  cfg_view;

    asa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_done     (cell_done),
        .push          (push),
        .push_word     (push_word),
        .cfg_view      (cfg_view)
    );

    asa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (cell_done),
        .head_word  (head_word),
        .head_valid (head_valid)
    );

    asa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_word     (head_word),
        .head_valid    (head_valid),
        .cfg_view      (cfg_view),
        .pop           (cell_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/asa_front.sv =====
// Front end: configuration registers, cell counters, intake credit and the
// six-stage arithmetic pipe that turns one cell into a queued cell word. Uses asa_pkg.
`include "anisotropic_stencil_assembler_core_defines.svh"

module asa_front #(
    parameter int MAX_WIDTH  = asa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = asa_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [asa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              cell_done,
    output logic                              push,
    output asa_pkg::cell_word_t               push_word,
    output asa_pkg::cfg_view_t                cfg_view
);

    localparam int DIM_MAX = 2**asa_pkg::DIM_W - 1;
    localparam logic [asa_pkg::DIM_W-1:0] MAX_W_DIM =
        asa_pkg::DIM_W'((MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
    localparam logic [asa_pkg::DIM_W-1:0] MAX_H_DIM =
        asa_pkg::DIM_W'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);
    localparam int OCC_W = $clog2(asa_pkg::QUEUE_DEPTH + 1);
    localparam int NSTG  = 6;

    logic [asa_pkg::DIM_W-1:0]   width_reg;
    logic [asa_pkg::DIM_W-1:0]   height_reg;
    logic [asa_pkg::RATIO_W-1:0] ryx_reg;
    logic [asa_pkg::RATIO_W-1:0] rxy_reg;
    logic [asa_pkg::DIM_W-1:0]   x_reg;
    logic [asa_pkg::DIM_W-1:0]   x_next;
    logic [asa_pkg::DIM_W-1:0]   y_reg;
    logic [asa_pkg::DIM_W-1:0]   y_next;
    logic [asa_pkg::ROW_W-1:0]   k_reg;
    logic [asa_pkg::ROW_W-1:0]   k_next;
    logic [OCC_W-1:0]            occ_reg;
    logic [OCC_W-1:0]            occ_next;
    logic [NSTG-1:0]             vld_reg;
    logic [asa_pkg::ROW_W-1:0]   dummy_reg;

    logic [asa_pkg::DIM_W-1:0]   w_eff;
    logic [asa_pkg::DIM_W-1:0]   h_eff;
    logic [2*asa_pkg::DIM_W-1:0] area;
    logic                        accept;
    logic                        dim_write;
    logic                        x_more;
    logic                        y_more;
    asa_pkg::border_t            border;

    logic signed [asa_pkg::COEF_W-1:0]  st1_coef [asa_pkg::NUM_COEF];
    logic [asa_pkg::ROW_W-1:0]          st1_k;
    asa_pkg::border_t                   st1_border;

    logic signed [asa_pkg::MUL_W-1:0]   mul_te;
    logic signed [asa_pkg::MUL_W-1:0]   mul_tw;
    logic signed [asa_pkg::MUL_W-1:0]   mul_tn;
    logic signed [asa_pkg::MUL_W-1:0]   mul_ts;
    logic signed [asa_pkg::PROD_W-1:0]  st2_te;
    logic signed [asa_pkg::PROD_W-1:0]  st2_tw;
    logic signed [asa_pkg::PROD_W-1:0]  st2_tn;
    logic signed [asa_pkg::PROD_W-1:0]  st2_ts;
    logic signed [asa_pkg::SUM_W-1:0]   st2_dns;
    logic signed [asa_pkg::SUM_W-1:0]   st2_dew;
    logic signed [asa_pkg::SUM_W-1:0]   st2_ne;
    logic signed [asa_pkg::SUM_W-1:0]   st2_sw;
    logic signed [asa_pkg::SUM_W-1:0]   st2_nw;
    logic signed [asa_pkg::SUM_W-1:0]   st2_se;
    logic [asa_pkg::ROW_W-1:0]          st2_k;
    asa_pkg::border_t                   st2_border;

    logic signed [asa_pkg::Q18_W-1:0]   st3_v [asa_pkg::NUM_NB];
    logic signed [asa_pkg::Q18_W-1:0]   st3_c1;
    logic signed [asa_pkg::Q18_W-1:0]   st3_c2;
    logic [asa_pkg::NUM_NB-1:0]         st3_fold;
    logic [asa_pkg::ROW_W-1:0]          st3_k;
    asa_pkg::border_t                   st3_border;

    logic signed [asa_pkg::Q18_W-1:0]   fold_v [asa_pkg::NUM_NB];
    logic signed [asa_pkg::Q18_W-1:0]   st4_sa;
    logic signed [asa_pkg::Q18_W-1:0]   st4_sb;
    logic signed [asa_pkg::Q18_W-1:0]   st4_sc;
    logic [asa_pkg::NUM_NB-1:0][asa_pkg::VAL_W-1:0] st4_nb;
    logic [asa_pkg::ROW_W-1:0]          st4_k;
    asa_pkg::border_t                   st4_border;

    logic signed [asa_pkg::Q18_W-1:0]   st5_centre;
    logic [asa_pkg::NUM_NB-1:0][asa_pkg::VAL_W-1:0] st5_nb;
    logic [asa_pkg::ROW_W-1:0]          st5_k;
    asa_pkg::border_t                   st5_border;

    asa_pkg::cell_word_t                st6_word;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = asa_pkg::DIM_W'(1);
        end
        else
        begin
            w_eff = (width_reg > MAX_W_DIM) ? MAX_W_DIM : width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = asa_pkg::DIM_W'(1);
        end
        else
        begin
            h_eff = (height_reg > MAX_H_DIM) ? MAX_H_DIM : height_reg;
        end
        area = w_eff * h_eff;
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (occ_reg < OCC_W'(asa_pkg::QUEUE_DEPTH));
    assign dim_write     = cfg_we && ((cfg_index == asa_pkg::REG_GRID_WIDTH)
                                   || (cfg_index == asa_pkg::REG_GRID_HEIGHT));
    assign x_more = ({1'b0, x_reg} + (asa_pkg::DIM_W+1)'(1)) < {1'b0, w_eff};
    assign y_more = ({1'b0, y_reg} + (asa_pkg::DIM_W+1)'(1)) < {1'b0, h_eff};

    always_comb
    begin
        border.xlo = (x_reg == '0);
        border.xhi = ~x_more;
        border.ylo = (y_reg == '0);
        border.yhi = ~y_more;
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        if (dim_write)
        begin
            x_next = '0;
            y_next = '0;
            k_next = '0;
        end
        else if (accept)
        begin
            if (x_more)
            begin
                x_next = x_reg + asa_pkg::DIM_W'(1);
                k_next = k_reg + asa_pkg::ROW_W'(1);
            end
            else
            begin
                x_next = '0;
                if (y_more)
                begin
                    y_next = y_reg + asa_pkg::DIM_W'(1);
                    k_next = k_reg + asa_pkg::ROW_W'(1);
                end
                else
                begin
                    y_next = '0;
                    k_next = '0;
                end
            end
        end
    end

    assign occ_next = occ_reg + OCC_W'(accept) - OCC_W'(cell_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= asa_pkg::DIM_W'(1);
            height_reg <= asa_pkg::DIM_W'(1);
            ryx_reg    <= asa_pkg::RATIO_W'(65536);
            rxy_reg    <= asa_pkg::RATIO_W'(65536);
            x_reg      <= '0;
            y_reg      <= '0;
            k_reg      <= '0;
            occ_reg    <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    asa_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data[asa_pkg::DIM_W-1:0];
                    asa_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data[asa_pkg::DIM_W-1:0];
                    asa_pkg::REG_RATIO_YX:    ryx_reg    <= cfg_data[asa_pkg::RATIO_W-1:0];
                    asa_pkg::REG_RATIO_XY:    rxy_reg    <= cfg_data[asa_pkg::RATIO_W-1:0];
                    default: ;
                endcase
            end
            x_reg   <= x_next;
            y_reg   <= y_next;
            k_reg   <= k_next;
            occ_reg <= occ_next;
            vld_reg <= {vld_reg[NSTG-2:0], accept};
        end
    end

    assign mul_te = $signed({1'b0, ryx_reg}) * st1_coef[0];
    assign mul_tw = $signed({1'b0, ryx_reg}) * st1_coef[1];
    assign mul_tn = $signed({1'b0, rxy_reg}) * st1_coef[2];
    assign mul_ts = $signed({1'b0, rxy_reg}) * st1_coef[3];

    always_comb
    begin
        for (int i = 0; i < asa_pkg::NUM_NB; i++)
        begin
            fold_v[i] = st3_fold[i] ? st3_v[i] : '0;
        end
    end

    // payload stages: hold no reset, qualified by vld_reg
    always_ff @(posedge clk)
    begin
        dummy_reg <= area[asa_pkg::ROW_W-1:0];

        for (int i = 0; i < asa_pkg::NUM_COEF; i++)
        begin
            st1_coef[i] <= $signed(s_axis_tdata[i*asa_pkg::COEF_W +: asa_pkg::COEF_W]);
        end
        st1_k      <= k_reg;
        st1_border <= border;

        st2_te     <= mul_te[asa_pkg::MUL_W-1:asa_pkg::FRAC_DROP];
        st2_tw     <= mul_tw[asa_pkg::MUL_W-1:asa_pkg::FRAC_DROP];
        st2_tn     <= mul_tn[asa_pkg::MUL_W-1:asa_pkg::FRAC_DROP];
        st2_ts     <= mul_ts[asa_pkg::MUL_W-1:asa_pkg::FRAC_DROP];
        st2_dns    <= asa_pkg::SUM_W'(st1_coef[4]) - asa_pkg::SUM_W'(st1_coef[5]);
        st2_dew    <= asa_pkg::SUM_W'(st1_coef[6]) - asa_pkg::SUM_W'(st1_coef[7]);
        st2_ne     <= asa_pkg::SUM_W'(st1_coef[4]) + asa_pkg::SUM_W'(st1_coef[6]);
        st2_sw     <= asa_pkg::SUM_W'(st1_coef[5]) + asa_pkg::SUM_W'(st1_coef[7]);
        st2_nw     <= asa_pkg::SUM_W'(st1_coef[4]) + asa_pkg::SUM_W'(st1_coef[7]);
        st2_se     <= asa_pkg::SUM_W'(st1_coef[5]) + asa_pkg::SUM_W'(st1_coef[6]);
        st2_k      <= st1_k;
        st2_border <= st1_border;

        st3_v[asa_pkg::NB_EAST]  <= asa_pkg::Q18_W'(st2_te) + asa_pkg::Q18_W'(st2_dns);
        st3_v[asa_pkg::NB_WEST]  <= asa_pkg::Q18_W'(st2_tw) - asa_pkg::Q18_W'(st2_dns);
        st3_v[asa_pkg::NB_NORTH] <= asa_pkg::Q18_W'(st2_tn) + asa_pkg::Q18_W'(st2_dew);
        st3_v[asa_pkg::NB_SOUTH] <= asa_pkg::Q18_W'(st2_ts) - asa_pkg::Q18_W'(st2_dew);
        st3_v[asa_pkg::NB_NE]    <= asa_pkg::Q18_W'(st2_ne);
        st3_v[asa_pkg::NB_SW]    <= asa_pkg::Q18_W'(st2_sw);
        st3_v[asa_pkg::NB_NW]    <= -asa_pkg::Q18_W'(st2_nw);
        st3_v[asa_pkg::NB_SE]    <= -asa_pkg::Q18_W'(st2_se);
        st3_c1     <= -asa_pkg::Q18_W'(st2_te) - asa_pkg::Q18_W'(st2_tw);
        st3_c2     <= -asa_pkg::Q18_W'(st2_tn) - asa_pkg::Q18_W'(st2_ts);
        for (int i = 0; i < asa_pkg::NUM_NB; i++)
        begin
            st3_fold[i] <= asa_pkg::is_folded(asa_pkg::nb_move(3'(i), st2_border));
        end
        st3_k      <= st2_k;
        st3_border <= st2_border;

        st4_sa     <= st3_c1 + st3_c2 + fold_v[0] + fold_v[1];
        st4_sb     <= fold_v[2] + fold_v[3] + fold_v[4] + fold_v[5];
        st4_sc     <= fold_v[6] + fold_v[7];
        for (int i = 0; i < asa_pkg::NUM_NB; i++)
        begin
            st4_nb[i] <= asa_pkg::finish(st3_v[i]);
        end
        st4_k      <= st3_k;
        st4_border <= st3_border;

        st5_centre <= st4_sa + st4_sb + st4_sc;
        st5_nb     <= st4_nb;
        st5_k      <= st4_k;
        st5_border <= st4_border;

        st6_word.centre <= asa_pkg::finish(st5_centre);
        st6_word.nb_val <= st5_nb;
        st6_word.k      <= st5_k;
        st6_word.border <= st5_border;
    end

    assign push           = vld_reg[NSTG-1];
    assign push_word      = st6_word;
    assign cfg_view.width = w_eff;
    assign cfg_view.dummy = dummy_reg;

    `ASA_ASSERT_NEXT(a_dim_write_restarts, clk, rst_n, dim_write, (x_reg == '0) && (y_reg == '0) && (k_reg == '0))
    `ASA_ASSERT_IMPLIES(a_credit_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(asa_pkg::QUEUE_DEPTH))

endmodule

// ===== rtl/asa_queue.sv =====
// Cell word queue between the front pipe and the triple sequencer.
// Register-based FIFO of asa_pkg::QUEUE_DEPTH entries; uses asa_pkg.
`include "anisotropic_stencil_assembler_core_defines.svh"

module asa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  asa_pkg::cell_word_t push_word,
    input  logic                pop,
    output asa_pkg::cell_word_t head_word,
    output logic                head_valid
);

    localparam int PTR_W = $clog2(asa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(asa_pkg::QUEUE_DEPTH + 1);

    asa_pkg::cell_word_t entry_reg [asa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                full;

    assign full       = (count_reg == CNT_W'(asa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    `ASA_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, push, !full)
    `ASA_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, pop, head_valid)

endmodule

// ===== rtl/asa_back.sv =====
// Back end: walks the head cell word through nine triples into the output
// register, one per cycle unless m_axis_tready stalls it. Uses asa_pkg.
`include "anisotropic_stencil_assembler_core_defines.svh"

module asa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  asa_pkg::cell_word_t               head_word,
    input  logic                              head_valid,
    input  asa_pkg::cfg_view_t                cfg_view,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [asa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    logic [asa_pkg::STEP_W-1:0] step_reg;
    logic [asa_pkg::STEP_W-1:0] step_next;
    logic                       out_valid_reg;
    logic [asa_pkg::ROW_W-1:0]  row_reg;
    logic [asa_pkg::COL_W-1:0]  col_reg;
    logic [asa_pkg::VAL_W-1:0]  val_reg;
    logic                       last_reg;

    logic                       load;
    logic [asa_pkg::STEP_W-1:0] nb_sel;
    asa_pkg::move_t             mv;
    logic [asa_pkg::ROW_W-1:0]  col_full;
    logic [asa_pkg::ROW_W-1:0]  w_ext;
    logic [asa_pkg::ROW_W-1:0]  row_val;
    logic [asa_pkg::VAL_W-1:0]  coef;

    assign load = head_valid && (!out_valid_reg || m_axis_tready);
    assign pop  = load && (step_reg == asa_pkg::STEP_LAST);
    assign step_next = (step_reg == asa_pkg::STEP_LAST) ? asa_pkg::STEP_CENTRE
                                                        : step_reg + asa_pkg::STEP_W'(1);
    assign nb_sel = step_reg - asa_pkg::STEP_W'(1);
    assign mv     = asa_pkg::nb_move(nb_sel[2:0], head_word.border);
    assign w_ext  = asa_pkg::ROW_W'(cfg_view.width);

    always_comb
    begin
        col_full = head_word.k + asa_pkg::ROW_W'(mv.xp) - asa_pkg::ROW_W'(mv.xm)
                 + (mv.yp ? w_ext : '0) - (mv.ym ? w_ext : '0);
        if (step_reg == asa_pkg::STEP_CENTRE)
        begin
            row_val  = head_word.k;
            col_full = head_word.k;
            coef     = head_word.centre;
        end
        else
        begin
            row_val = asa_pkg::is_folded(mv) ? cfg_view.dummy : head_word.k;
            coef    = head_word.nb_val[nb_sel[2:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= asa_pkg::STEP_CENTRE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= row_val;
            col_reg  <= col_full[asa_pkg::COL_W-1:0];
            val_reg  <= coef;
            last_reg <= (step_reg == asa_pkg::STEP_LAST);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{asa_pkg::OUT_PAD_W{1'b0}}, val_reg, col_reg, row_reg};
    assign m_axis_tlast  = last_reg;

    `ASA_ASSERT_IMPLIES(a_cell_held_mid_walk, clk, rst_n, step_reg != asa_pkg::STEP_CENTRE, head_valid)
    `ASA_ASSERT_IMPLIES(a_step_bound, clk, rst_n, 1'b1, step_reg <= asa_pkg::STEP_LAST)

endmodule
